// ----- rtl/mprbs_pkg.sv -----
// Shared types, constants and the LFSR step function of the multichannel PRBS32 generator.
`timescale 1ns / 1ps
`default_nettype none

package mprbs_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned LCOUNT_W  = 5;
  localparam int unsigned BLEN_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] TAP_MASK   = 32'h8000_0062;
  localparam logic [WORD_W-1:0] LOW31_MASK = 32'h7FFF_FFFF;

  localparam logic [WORD_W-1:0]   SEED_RST  = 32'h0000_0001;
  localparam logic [LCOUNT_W-1:0] LCOUNT_RST = 5'd1;
  localparam logic [BLEN_W-1:0]   BLEN_RST  = 24'd1024;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED         = 3'd0,
    CFG_LANE_COUNT   = 3'd1,
    CFG_BLOCK_LENGTH = 3'd2,
    CFG_INCLUDE_ZERO = 3'd3,
    CFG_SEED_FIRST   = 3'd4
  } cfg_idx_t;

  // One Fibonacci step: shift left, feedback from taps 31, 6, 5, 1.
  function automatic word_t prbs_step(input word_t w, input logic incl_zero);
    logic fb;
    fb = ^(w & TAP_MASK);
    if (incl_zero && ((w & LOW31_MASK) == '0)) begin
      fb = ~fb;
    end
    return {w[WORD_W-2:0], fb};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mprbs_lane_ram.sv -----
// Lane word memory: one write port, one registered read port, write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none

module mprbs_lane_ram
  import mprbs_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q_r;
  logic [WORD_W-1:0] fwd_data_r;
  logic              fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

`default_nettype wire

// ----- rtl/multichannel_prbs32_generator_top.sv -----
// Multichannel PRBS32 word generator: one word per input beat from interleaved lanes.
// Pipeline: lane read and stage-1 registers, then the step and output register.
// Throughput: one word per cycle while out_ready stays high; the lane memory (one read, one
// write port) is read in the accept cycle and written when the beat leaves stage 1, with
// forwarding when consecutive beats hit the same lane.
// Reset: synchronous, active low; clears pipeline valids, block position and lane pointer, and
// loads config defaults. Lane memory is not cleared; the first pass of each block refills it.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_prbs32_generator_top
  import mprbs_pkg::*;
#(
  parameter int unsigned MAX_LANES   = 16,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_restart,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WORD_W-1:0]         out_word,
  output logic                      out_last
);

  localparam int unsigned PTR_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LANES + 1);
  localparam int unsigned CMP_W = LENGTH_BITS + 1;

  logic [WORD_W-1:0]      seed_r;
  logic [LCOUNT_W-1:0]    lcount_r;
  logic [BLEN_W-1:0]      blen_r;
  logic                   incl_zero_r;
  logic                   seed_first_r;

  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;

  logic                   s1_v_r;
  logic                   s1_seedw_r;
  logic                   s1_usemem_r;
  logic                   s1_last_r;
  logic [WORD_W-1:0]      s1_base_r;
  logic [PTR_W-1:0]       s1_ptr_r;

  logic                   out_v_r;
  logic [WORD_W-1:0]      out_word_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   s1_go;
  logic [CNT_W-1:0]       lanes;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] pos0;
  logic [PTR_W-1:0]       ptr0;
  logic [LENGTH_BITS-1:0] k;
  logic [CNT_W-1:0]       ptr_inc;
  logic                   seedw;
  logic                   first_pass;
  logic                   last;
  logic [WORD_W-1:0]      mem_rd;
  logic [WORD_W-1:0]      s1_src;
  logic [WORD_W-1:0]      s1_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= SEED_RST;
      lcount_r     <= LCOUNT_RST;
      blen_r       <= BLEN_RST;
      incl_zero_r  <= 1'b1;
      seed_first_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEED:         seed_r       <= cfg_wdata;
        CFG_LANE_COUNT:   lcount_r     <= cfg_wdata[LCOUNT_W-1:0];
        CFG_BLOCK_LENGTH: blen_r       <= cfg_wdata[BLEN_W-1:0];
        CFG_INCLUDE_ZERO: incl_zero_r  <= cfg_wdata[0];
        CFG_SEED_FIRST:   seed_first_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign s1_go    = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  // Stage 0: block position and lane selection
  always_comb begin
    logic [BLEN_W+LENGTH_BITS-1:0] blen_ext;
    if (lcount_r == '0) begin
      lanes = CNT_W'(1);
    end else if (32'(lcount_r) > 32'(MAX_LANES)) begin
      lanes = CNT_W'(MAX_LANES);
    end else begin
      lanes = CNT_W'(lcount_r);
    end

    blen_ext = {{LENGTH_BITS{1'b0}}, blen_r};
    len      = blen_ext[LENGTH_BITS-1:0];
    if (len == '0) begin
      len = LENGTH_BITS'(1);
    end

    pos0 = in_restart ? '0 : pos_r;
    ptr0 = in_restart ? '0 : ptr_r;
    if (CNT_W'(ptr0) >= lanes) begin
      ptr0 = '0;
    end

    seedw      = seed_first_r && (pos0 == '0);
    k          = pos0 - LENGTH_BITS'(seed_first_r);
    first_pass = CMP_W'(k) < CMP_W'(lanes);
    ptr_inc    = CNT_W'(ptr0) + CNT_W'(1);
    last       = (CMP_W'(pos0) + CMP_W'(1)) >= CMP_W'(len);

    ptr_nxt = ptr0;
    if (!seedw) begin
      ptr_nxt = (ptr_inc >= lanes) ? '0 : PTR_W'(ptr_inc);
    end
    pos_nxt = pos0 + LENGTH_BITS'(1);
    if (last) begin
      pos_nxt = '0;
      ptr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ptr_r <= '0;
    end else if (in_acc) begin
      pos_r <= pos_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_seedw_r  <= seedw;
      s1_usemem_r <= !seedw && !first_pass;
      s1_last_r   <= last;
      s1_base_r   <= seedw ? seed_r : seed_r + WORD_W'(ptr0);
      s1_ptr_r    <= ptr0;
    end
  end

  mprbs_lane_ram #(
    .DEPTH  (MAX_LANES),
    .ADDR_W (PTR_W)
  ) u_lane_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (ptr0),
    .rd_data (mem_rd),
    .wr_en   (s1_go && !s1_seedw_r),
    .wr_addr (s1_ptr_r),
    .wr_data (s1_word)
  );

  // Stage 1: step and write back
  assign s1_src  = s1_usemem_r ? mem_rd : s1_base_r;
  assign s1_word = s1_seedw_r ? s1_base_r : prbs_step(s1_src, incl_zero_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_word_r <= s1_word;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/mprbs_checker.sv -----
// Port-level checker for the multichannel PRBS32 generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mprbs_checker
  import mprbs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WORD_W-1:0] out_word,
  input wire logic              out_last
);

  logic [2:0] pend_r;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_beat && !out_beat) begin
      pend_r <= pend_r + 3'd1;
    end else if (!in_beat && out_beat) begin
      pend_r <= pend_r - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("result beat dropped or changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result beat without a pending input beat");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("more beats in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 3'd0 |-> in_ready)
    else $error("input stalled while pipeline empty");

endmodule

bind multichannel_prbs32_generator_top mprbs_checker u_mprbs_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the multichannel PRBS32 generator with a scoreboard class.
`timescale 1ns / 1ps

module testbench;
  import mprbs_pkg::*;

  localparam int unsigned LANES_MAX = 16;
  localparam int unsigned RANDOM_BEATS = 1300;

  typedef struct {
    word_t word;
    logic  last;
  } word_beat_t;

  class prbs_scoreboard;
    word_t                seed;
    logic [LCOUNT_W-1:0]  lane_count;
    logic [BLEN_W-1:0]    block_len;
    bit                   incl_zero;
    bit                   seed_first;
    word_t                lane_hist[LANES_MAX];
    int unsigned          pos;
    int unsigned          lane_ptr;
    word_beat_t           expected_q[$];
    int                   errors;

    function new();
      seed       = SEED_RST;
      lane_count = LCOUNT_RST;
      block_len  = BLEN_RST;
      incl_zero  = 1'b1;
      seed_first = 1'b0;
      pos        = 0;
      lane_ptr   = 0;
      errors     = 0;
      foreach (lane_hist[i]) lane_hist[i] = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, word_t v);
      case (idx)
        CFG_SEED:         seed = v;
        CFG_LANE_COUNT:   lane_count = v[LCOUNT_W-1:0];
        CFG_BLOCK_LENGTH: block_len = v[BLEN_W-1:0];
        CFG_INCLUDE_ZERO: incl_zero = v[0];
        CFG_SEED_FIRST:   seed_first = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned lanes_eff();
      if (lane_count == 0) return 1;
      if (lane_count > LANES_MAX) return LANES_MAX;
      return lane_count;
    endfunction

    // taps 31, 6, 5, 1; optional zero insertion
    function word_t advance_lfsr(word_t w);
      logic fb;
      fb = w[31] ^ w[6] ^ w[5] ^ w[1];
      if (incl_zero && w[30:0] == 31'd0) fb = ~fb;
      return {w[30:0], fb};
    endfunction

    function void note_beat(bit restart);
      int unsigned n_lanes;
      int unsigned len;
      int unsigned k;
      word_beat_t  e;
      n_lanes = lanes_eff();
      len = (block_len == 0) ? 1 : block_len;
      if (restart) begin
        pos = 0;
        lane_ptr = 0;
      end
      if (lane_ptr >= n_lanes) lane_ptr = 0;
      if (seed_first && pos == 0) begin
        e.word = seed;
      end else begin
        k = pos - (seed_first ? 1 : 0);
        if (k < n_lanes) e.word = advance_lfsr(seed + word_t'(lane_ptr));
        else e.word = advance_lfsr(lane_hist[lane_ptr]);
        lane_hist[lane_ptr] = e.word;
        lane_ptr = (lane_ptr + 1 >= n_lanes) ? 0 : lane_ptr + 1;
      end
      e.last = (pos + 1 >= len);
      if (e.last) begin
        pos = 0;
        lane_ptr = 0;
      end else begin
        pos = pos + 1;
      end
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(word_t w, logic l);
      word_beat_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat word=%h last=%b", w, l));
        return;
      end
      e = expected_q.pop_front();
      if (w !== e.word) report($sformatf("word %h, expected %h", w, e.word));
      if (l !== e.last) report($sformatf("last %b, expected %b (word %h)", l, e.last, e.word));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    out_word;
  logic                 out_last;

  prbs_scoreboard sb;
  bit             no_gaps = 1'b0;
  int unsigned    beats_sent = 0;

  multichannel_prbs32_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .out_last   (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_beat(in_restart);
      if (out_valid && out_ready) sb.check_result(out_word, out_last);
    end
  end

  task automatic send_beat(input bit restart);
    if (!no_gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_beats(input int n, input bit first_restart, input int restart_pct);
    for (int i = 0; i < n; i++) begin
      send_beat((i == 0 && first_restart) || ($urandom_range(99) < restart_pct));
      beats_sent++;
    end
  endtask

  // sender holds off until the generator has delivered everything
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  initial begin
    int unsigned old_lanes;
    bit          old_sf;
    bit          need_restart;
    int          phase;
    word_t       v;

    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config
    run_beats(2, 1'b0, 0);

    // lane count zero, block length zero, seed word only
    drain();
    write_reg(CFG_SEED, 32'hFFFF_FFFE);
    write_reg(CFG_LANE_COUNT, 32'd0);
    write_reg(CFG_BLOCK_LENGTH, 32'd0);
    write_reg(CFG_INCLUDE_ZERO, 32'd0);
    write_reg(CFG_SEED_FIRST, 32'd1);
    cfg_wr_en <= 1'b0;
    run_beats(2, 1'b0, 0);

    // saturated lane count, longest block, seed+i crosses zero
    drain();
    write_reg(CFG_SEED, 32'hFFFF_FFFD);
    write_reg(CFG_LANE_COUNT, 32'd31);
    write_reg(CFG_BLOCK_LENGTH, 32'h00FF_FFFF);
    write_reg(CFG_INCLUDE_ZERO, 32'd1);
    write_reg(CFG_SEED_FIRST, 32'd0);
    cfg_wr_en <= 1'b0;
    run_beats(4, 1'b1, 0);

    // shorten block and lower lane count mid-block
    drain();
    write_reg(CFG_BLOCK_LENGTH, 32'd2);
    write_reg(CFG_LANE_COUNT, 32'd3);
    cfg_wr_en <= 1'b0;
    run_beats(4, 1'b0, 0);

    // all-zero seed without zero insertion
    drain();
    write_reg(CFG_SEED, 32'd0);
    write_reg(CFG_INCLUDE_ZERO, 32'd0);
    write_reg(CFG_BLOCK_LENGTH, 32'd5);
    write_reg(CFG_LANE_COUNT, 32'd2);
    cfg_wr_en <= 1'b0;
    run_beats(5, 1'b1, 0);

    phase = 0;
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      drain();
      old_lanes = sb.lanes_eff();
      old_sf = sb.seed_first;
      if ($urandom_range(1)) begin
        case ($urandom_range(5))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h8000_0000;
          default: v = $urandom;
        endcase
        write_reg(CFG_SEED, v);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0: v = 32'd0;
          1: v = 32'd16;
          2: v = $urandom_range(17, 31);
          default: v = $urandom_range(1, 8);
        endcase
        write_reg(CFG_LANE_COUNT, v);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: v = 32'd0;
          1: v = 32'h00FF_FFFF;
          2: v = 32'd1;
          default: v = $urandom_range(2, 40);
        endcase
        write_reg(CFG_BLOCK_LENGTH, v);
      end
      if ($urandom_range(1)) write_reg(CFG_INCLUDE_ZERO, $urandom_range(1));
      if ($urandom_range(1)) write_reg(CFG_SEED_FIRST, $urandom_range(1));
      cfg_wr_en <= 1'b0;
      // more lanes or dropping the seed word mid-block would read unfilled lanes
      need_restart = (sb.lanes_eff() > old_lanes) || (old_sf && !sb.seed_first);
      no_gaps = (phase == 4);
      run_beats(no_gaps ? 200 : $urandom_range(10, 80), need_restart, 5);
      no_gaps = 1'b0;
      phase++;
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
